// ===== src/hufd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the huffman tree byte decoder
package hufd_pkg;

   localparam int COUNT_BITS = 24;
   localparam int LEN_BITS = 24;
   localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
   localparam int NODE_BITS = 8;
   localparam int NODE_COUNT = 255;
   localparam int ENTRY_BITS = 32;
   localparam int BRANCH_BITS = 16;
   localparam int CODE_BITS = 8;
   localparam int BIT_SEL_BITS = 3;

   localparam logic [NODE_BITS-1:0] ROOT_NODE = 8'd254;
   localparam logic [NODE_BITS-1:0] BAD_INDEX = 8'd255;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_BITS = 2;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = 2;

   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_LENGTH = 1'b0;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_DECODE = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;

   localparam logic [1:0] ST_BYTE = 2'd0;
   localparam logic [1:0] ST_FINAL = 2'd1;
   localparam logic [1:0] ST_FAULT = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [NODE_BITS-1:0] node_index;
      logic [ENTRY_BITS-1:0] entry;
      logic [CODE_BITS-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic last_of_run;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== src/huffman_tree_byte_decoder.sv =====
`timescale 1ns / 1ps
// Huffman decoder that walks a 255-node tree held in an on-chip node memory.
// Load items write one node, start items rewind the walk to the root (node 254)
// and clear the byte count, decode items consume a code byte lsb first and give
// up to eight result items. Items go through a four-entry command queue to the
// walker, results through a four-entry result queue. A decode item passes the
// walker through a node read that fetches the current node, up to eight walk
// steps of one node read each, and a flush state that releases the final result;
// it ends sooner when the sequence ends or a bad pointer halts it in mid byte.
// Each walk step needs the node read of the step before. Load and start items,
// and decode items that are ignored, are taken in the idle state with no walk.
// A stalled consumer stops the walker once the result queue is full. Unwritten
// nodes read back as garbage; there is no clearing pass.
// output_length sits at byte address 0 and resets to 1.
module huffman_tree_byte_decoder import hufd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [1:0] req_action,
   input  logic [NODE_BITS-1:0] req_node_index,
   input  logic [BRANCH_BITS-1:0] req_branch_zero,
   input  logic [BRANCH_BITS-1:0] req_branch_one,
   input  logic [CODE_BITS-1:0] req_code_byte,
   output logic empty,
   input  logic pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic rsp_last_of_run,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic pready
);

   logic [LEN_BITS-1:0] length_ff, length_in;
   logic csr_write;
   q_stat_type cmd_stat, rsp_stat;
   cmd_type cmd_wdata, cmd_rdata;
   logic cmd_push, cmd_pop;
   logic rsp_push;
   rsp_type rsp_wdata, rsp_rdata;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH);
   assign length_in = csr_write ? pwdata[LEN_BITS-1:0] : length_ff;
   assign prdata = (paddr[2] == REG_LENGTH) ? DATA_BITS'(length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_BITS'(1);
      end else begin
         length_ff <= length_in;
      end
   end

   assign full = cmd_stat.full;
   assign empty = rsp_stat.empty;
   assign rsp_out_byte = rsp_rdata.out_byte;
   assign rsp_status = rsp_rdata.status;
   assign rsp_last_of_run = rsp_rdata.last_of_run;

   hufd_front u_front (
      .push(push),
      .cmd_stat(cmd_stat),
      .action(req_action),
      .node_index(req_node_index),
      .branch_zero(req_branch_zero),
      .branch_one(req_branch_one),
      .code_byte(req_code_byte),
      .cmd_push(cmd_push),
      .cmd(cmd_wdata)
   );

   hufd_cmd_queue u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .wdata(cmd_wdata),
      .pop(cmd_pop),
      .rdata(cmd_rdata),
      .stat(cmd_stat)
   );

   hufd_back u_back (
      .clock(clock),
      .reset(reset),
      .output_length(length_ff),
      .cmd_stat(cmd_stat),
      .cmd(cmd_rdata),
      .cmd_pop(cmd_pop),
      .rsp_stat(rsp_stat),
      .rsp_push(rsp_push),
      .rsp(rsp_wdata)
   );

   hufd_rsp_queue u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .wdata(rsp_wdata),
      .pop(pop),
      .rdata(rsp_rdata),
      .stat(rsp_stat)
   );

endmodule

// ===== src/hufd_front.sv =====
`timescale 1ns / 1ps
// front end: takes input items, drops the meaningless ones and packs commands
module hufd_front import hufd_pkg::*; (
   input  logic push,
   input  q_stat_type cmd_stat,
   input  logic [1:0] action,
   input  logic [NODE_BITS-1:0] node_index,
   input  logic [BRANCH_BITS-1:0] branch_zero,
   input  logic [BRANCH_BITS-1:0] branch_one,
   input  logic [CODE_BITS-1:0] code_byte,
   output logic cmd_push,
   output cmd_type cmd
);

   logic keep;

   always_comb begin
      keep = 1'b0;
      case (action)
         ACT_LOAD: keep = (node_index != BAD_INDEX);
         ACT_DECODE: keep = 1'b1;
         ACT_START: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   assign cmd_push = push && !cmd_stat.full && keep;
   assign cmd.kind = action;
   assign cmd.node_index = node_index;
   assign cmd.entry = {branch_one, branch_zero};
   assign cmd.code = code_byte;

endmodule

// ===== src/hufd_cmd_queue.sv =====
`timescale 1ns / 1ps
// short command queue between front end and tree walker
module hufd_cmd_queue import hufd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cmd_type wdata,
   input  logic pop,
   output cmd_type rdata,
   output q_stat_type stat
);

   cmd_type slot_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   assign stat.full = (count_ff == (CMD_PTR_BITS+1)'(CMD_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/hufd_rsp_queue.sv =====
`timescale 1ns / 1ps
// result queue that decouples the tree walker from the consumer
module hufd_rsp_queue import hufd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rsp_type wdata,
   input  logic pop,
   output rsp_type rdata,
   output q_stat_type stat
);

   rsp_type slot_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   assign stat.full = (count_ff == (RSP_PTR_BITS+1)'(RSP_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/hufd_back.sv =====
`timescale 1ns / 1ps
// back end: node memory and the bit-by-bit tree walker
module hufd_back import hufd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [LEN_BITS-1:0] output_length,
   input  q_stat_type cmd_stat,
   input  cmd_type cmd,
   output logic cmd_pop,
   input  q_stat_type rsp_stat,
   output logic rsp_push,
   output rsp_type rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [ENTRY_BITS-1:0] node_mem [NODE_COUNT];
   logic [ENTRY_BITS-1:0] entry_ff;

   logic [1:0] state_ff, state_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic finished_ff, finished_in;
   logic fault_ff, fault_in;
   logic [BIT_SEL_BITS-1:0] bit_ff, bit_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [1:0] held_status_ff, held_status_in;
   logic held_valid_ff, held_valid_in;

   logic mem_we, mem_re;
   logic [NODE_BITS-1:0] mem_raddr;
   logic [BRANCH_BITS-1:0] branch;
   logic is_leaf, is_inner, step_res, hit, stall, terminal;
   logic [COUNT_BITS-1:0] count_inc;
   logic [1:0] res_status;
   logic [7:0] res_byte;

   assign branch = code_ff[bit_ff] ? entry_ff[ENTRY_BITS-1:BRANCH_BITS]
                                   : entry_ff[BRANCH_BITS-1:0];
   assign is_leaf = (branch[15:8] == 8'd0);
   assign is_inner = (branch[15:9] == 7'd0) && branch[8] && (branch[7:0] != 8'hFF);
   assign step_res = !is_inner;
   assign count_inc = count_ff + 1'b1;
   assign hit = (CMP_BITS'(count_inc) == CMP_BITS'(output_length));
   assign res_status = is_leaf ? (hit ? ST_FINAL : ST_BYTE) : ST_FAULT;
   assign res_byte = is_leaf ? branch[7:0] : 8'd0;
   assign stall = step_res && held_valid_ff && rsp_stat.full;
   assign terminal = !is_inner && (!is_leaf || hit) || (bit_ff == 3'd7);

   assign rsp.out_byte = held_byte_ff;
   assign rsp.status = held_status_ff;
   assign rsp.last_of_run = (state_ff == S_FLUSH);

   always_comb begin
      state_in = state_ff;
      node_in = node_ff;
      count_in = count_ff;
      finished_in = finished_ff;
      fault_in = fault_ff;
      bit_in = bit_ff;
      code_in = code_ff;
      held_byte_in = held_byte_ff;
      held_status_in = held_status_ff;
      held_valid_in = held_valid_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_raddr = node_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_stat.empty) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  ACT_LOAD: begin
                     mem_we = 1'b1;
                  end
                  ACT_START: begin
                     node_in = ROOT_NODE;
                     count_in = '0;
                     finished_in = 1'b0;
                     fault_in = 1'b0;
                  end
                  ACT_DECODE: begin
                     if (!finished_ff && !fault_ff) begin
                        mem_re = 1'b1;
                        mem_raddr = node_ff;
                        code_in = cmd.code;
                        bit_in = '0;
                        state_in = S_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (!stall) begin
               if (step_res) begin
                  rsp_push = held_valid_ff;
                  held_byte_in = res_byte;
                  held_status_in = res_status;
                  held_valid_in = 1'b1;
               end
               if (is_leaf) begin
                  node_in = ROOT_NODE;
                  count_in = count_inc;
                  if (hit) begin
                     finished_in = 1'b1;
                  end
               end else if (is_inner) begin
                  node_in = branch[7:0];
               end else begin
                  fault_in = 1'b1;
               end
               mem_re = 1'b1;
               mem_raddr = is_inner ? branch[7:0] : ROOT_NODE;
               bit_in = bit_ff + 1'b1;
               if (terminal) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (held_valid_ff) begin
               if (!rsp_stat.full) begin
                  rsp_push = 1'b1;
                  held_valid_in = 1'b0;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         node_ff <= ROOT_NODE;
         count_ff <= '0;
         finished_ff <= 1'b0;
         fault_ff <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_ff <= node_in;
         count_ff <= count_in;
         finished_ff <= finished_in;
         fault_ff <= fault_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      code_ff <= code_in;
      held_byte_ff <= held_byte_in;
      held_status_ff <= held_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[cmd.node_index] <= cmd.entry;
      end
      if (mem_re) begin
         entry_ff <= node_mem[mem_raddr];
      end
   end

endmodule

// ===== src/hufd_checker.sv =====
`timescale 1ns / 1ps
// port checker for the huffman tree byte decoder and its bind
module hufd_checker import hufd_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input logic full,
   input logic [1:0] req_action,
   input logic [NODE_BITS-1:0] req_node_index,
   input logic [BRANCH_BITS-1:0] req_branch_zero,
   input logic [BRANCH_BITS-1:0] req_branch_one,
   input logic [CODE_BITS-1:0] req_code_byte,
   input logic empty,
   input logic pop,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic rsp_last_of_run,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [ADDR_BITS-1:0] paddr,
   input logic [DATA_BITS-1:0] pwdata,
   input logic [DATA_BITS-1:0] prdata,
   input logic pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_byte) && $stable(rsp_status)
         && $stable(rsp_last_of_run))
      else $error("waiting item changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status == ST_BYTE || rsp_status == ST_FINAL || rsp_status == ST_FAULT)
      else $error("bad status code");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_status == ST_FAULT || rsp_status == ST_FINAL) |-> rsp_last_of_run
         && (rsp_status != ST_FAULT || rsp_out_byte == 8'd0))
      else $error("final or fault item not last of run");

   a_length_read: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[2] == REG_LENGTH |=> prdata[DATA_BITS-1:LEN_BITS] == '0
         && (paddr[2] != REG_LENGTH || prdata[LEN_BITS-1:0] == $past(pwdata[LEN_BITS-1:0])))
      else $error("length register readback wrong");

endmodule

bind huffman_tree_byte_decoder hufd_checker u_hufd_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the huffman tree byte decoder: directed table, then random tree phases
module tb_top;
   import hufd_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [ADDR_BITS-1:0] LENGTH_ADDR = ADDR_BITS'(4 * int'(REG_LENGTH));
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 32;

   typedef struct packed {
      logic [1:0] act;
      logic [NODE_BITS-1:0] idx;
      logic [BRANCH_BITS-1:0] b0;
      logic [BRANCH_BITS-1:0] b1;
      logic [CODE_BITS-1:0] code;
   } huff_item_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      huff_item_type it;
      logic [DATA_BITS-1:0] cfg;
      int n_typed;
      rsp_type t0;
      rsp_type t1;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [1:0] req_action = '0;
   logic [NODE_BITS-1:0] req_node_index = '0;
   logic [BRANCH_BITS-1:0] req_branch_zero = '0;
   logic [BRANCH_BITS-1:0] req_branch_one = '0;
   logic [CODE_BITS-1:0] req_code_byte = '0;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic rsp_last_of_run;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic pready;

   huffman_tree_byte_decoder dut (
      .clock, .reset, .push, .full,
      .req_action, .req_node_index, .req_branch_zero, .req_branch_one, .req_code_byte,
      .empty, .pop, .rsp_out_byte, .rsp_status, .rsp_last_of_run,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #6 clock = ~clock;

   // decoder state mirror
   logic [ENTRY_BITS-1:0] tree_mem [NODE_COUNT];
   logic [NODE_BITS-1:0] cur_node = ROOT_NODE;
   logic [COUNT_BITS-1:0] emitted = '0;
   logic seq_done = 1'b0;
   logic seq_fault = 1'b0;
   logic [LEN_BITS-1:0] out_length = LEN_BITS'(1);

   rsp_type walk_out[$];
   rsp_type decoded_q[$];
   bit node_live [NODE_COUNT];
   int live_list[$];

   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;
   int cycle_count = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int cfg_writes = 0;
   int final_seen = 0;
   int fault_seen = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   function automatic void walk_tree(input huff_item_type it);
      logic [ENTRY_BITS-1:0] ent;
      logic [BRANCH_BITS-1:0] br;
      rsp_type r;
      walk_out.delete();
      if (it.act == ACT_LOAD) begin
         if (it.idx < NODE_COUNT) tree_mem[it.idx] = {it.b1, it.b0};
         return;
      end
      if (it.act == ACT_START) begin
         cur_node = ROOT_NODE;
         emitted = '0;
         seq_done = 1'b0;
         seq_fault = 1'b0;
         return;
      end
      if (it.act != ACT_DECODE || seq_done || seq_fault) return;
      for (int b = 0; b < CODE_BITS; b++) begin
         ent = tree_mem[cur_node];
         br = it.code[b] ? ent[31:16] : ent[15:0];
         if (br <= 16'd255) begin
            cur_node = ROOT_NODE;
            emitted = emitted + 1'b1;
            r.out_byte = br[7:0];
            r.status = ST_BYTE;
            r.last_of_run = 1'b0;
            if (CMP_BITS'(emitted) == CMP_BITS'(out_length)) begin
               r.status = ST_FINAL;
               seq_done = 1'b1;
            end
            walk_out.push_back(r);
            if (seq_done) break;
         end else if (br <= 16'd510) begin
            cur_node = NODE_BITS'(br - 16'd256);
         end else begin
            seq_fault = 1'b1;
            r.out_byte = '0;
            r.status = ST_FAULT;
            r.last_of_run = 1'b0;
            walk_out.push_back(r);
            break;
         end
      end
      if (walk_out.size() > 0) walk_out[walk_out.size() - 1].last_of_run = 1'b1;
   endfunction

   // branches only point at nodes already loaded, so no walk reaches an unloaded node
   function automatic logic [BRANCH_BITS-1:0] pick_branch(input logic [NODE_BITS-1:0] idx);
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 45) return BRANCH_BITS'($urandom_range(0, 255));
      if (pick < 90) begin
         k = $urandom_range(0, live_list.size());
         if (k < live_list.size()) return BRANCH_BITS'(256 + live_list[k]);
         return BRANCH_BITS'(256 + int'(idx));
      end
      return BRANCH_BITS'($urandom_range(511, 65535));
   endfunction

   function automatic huff_item_type random_item();
      huff_item_type it;
      int pick;
      int where;
      it.idx = NODE_BITS'($urandom);
      it.b0 = BRANCH_BITS'($urandom);
      it.b1 = BRANCH_BITS'($urandom);
      it.code = CODE_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         it.act = ACT_LOAD;
         where = $urandom_range(0, 99);
         if (where < 70) it.idx = NODE_BITS'($urandom_range(0, 15));
         else if (where < 88) it.idx = ROOT_NODE;
         else if (where < 96) it.idx = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
         else it.idx = BAD_INDEX;
         it.b0 = pick_branch(it.idx);
         it.b1 = pick_branch(it.idx);
      end else if (pick < 85) begin
         it.act = ACT_DECODE;
      end else if (pick < 95) begin
         it.act = ACT_START;
      end else begin
         it.act = ACT_NONE;
      end
      return it;
   endfunction

   function automatic rsp_type mk_rsp(input logic [7:0] b, input logic [1:0] s, input logic l);
      rsp_type r;
      r.out_byte = b;
      r.status = s;
      r.last_of_run = l;
      return r;
   endfunction

   function automatic plan_row_type item_row(input logic [1:0] a,
                                             input logic [NODE_BITS-1:0] i,
                                             input logic [BRANCH_BITS-1:0] z,
                                             input logic [BRANCH_BITS-1:0] o,
                                             input logic [CODE_BITS-1:0] c, input int n,
                                             input rsp_type r0, input rsp_type r1);
      plan_row_type p;
      p.kind = ROW_ITEM;
      p.it = {a, i, z, o, c};
      p.cfg = '0;
      p.n_typed = n;
      p.t0 = r0;
      p.t1 = r1;
      return p;
   endfunction

   function automatic plan_row_type cfg_row(input logic [DATA_BITS-1:0] v);
      plan_row_type p;
      p.kind = ROW_CFG;
      p.it = '0;
      p.cfg = v;
      p.n_typed = 0;
      p.t0 = '0;
      p.t1 = '0;
      return p;
   endfunction

   task automatic send_item(input huff_item_type it, input int n_typed, input rsp_type t0,
                            input rsp_type t1);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_action <= it.act;
      req_node_index <= it.idx;
      req_branch_zero <= it.b0;
      req_branch_one <= it.b1;
      req_code_byte <= it.code;
      do @(posedge clock); while (full);
      items_sent++;
      if (it.act == ACT_LOAD && it.idx < NODE_COUNT && !node_live[it.idx]) begin
         node_live[it.idx] = 1'b1;
         live_list.push_back(int'(it.idx));
      end
      walk_tree(it);
      if (n_typed < 0) begin
         foreach (walk_out[k]) decoded_q.push_back(walk_out[k]);
      end else begin
         if (n_typed > 0) decoded_q.push_back(t0);
         if (n_typed > 1) decoded_q.push_back(t1);
      end
   endtask

   task automatic csr_access(input logic wr, input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= LENGTH_ADDR;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // only while idle: results drained, then let queued no-result items finish
   task automatic write_length(input logic [DATA_BITS-1:0] v);
      logic [DATA_BITS-1:0] rd;
      push <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, v, rd);
      out_length = LEN_BITS'(v);
      cfg_writes++;
      csr_access(1'b0, '0, rd);
      if (rd !== DATA_BITS'(out_length))
         report($sformatf("output_length reads %08h, wrote %08h", rd, v));
   endtask

   initial begin
      rsp_type want;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = recv_steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         results_seen++;
         if (rsp_status == ST_FINAL) final_seen++;
         if (rsp_status == ST_FAULT) fault_seen++;
         if (decoded_q.size() == 0) begin
            report($sformatf("unexpected item byte %02h status %0d last %0b",
                             rsp_out_byte, rsp_status, rsp_last_of_run));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report($sformatf("result %0d out_byte %02h, want %02h",
                                results_seen, rsp_out_byte, want.out_byte));
            if (rsp_status !== want.status)
               report($sformatf("result %0d status %0d, want %0d",
                                results_seen, rsp_status, want.status));
            if (rsp_last_of_run !== want.last_of_run)
               report($sformatf("result %0d last_of_run %0b, want %0b",
                                results_seen, rsp_last_of_run, want.last_of_run));
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      logic [DATA_BITS-1:0] rd;
      logic [DATA_BITS-1:0] len_val;
      huff_item_type it;
      int phase_items;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, '0, rd);
      if (rd !== DATA_BITS'(out_length))
         report($sformatf("output_length after reset reads %08h", rd));

      // length 1 from reset
      plan.push_back(item_row(ACT_LOAD, ROOT_NODE, 16'h0041, 16'd509, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_LOAD, 8'd253, 16'h00FF, 16'hFFFF, 8'hFF, 0, '0, '0));
      plan.push_back(item_row(ACT_LOAD, BAD_INDEX, 16'hFFFF, 16'hFFFF, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0, '0, '0));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h00, 1,
                              mk_rsp(8'h41, ST_FINAL, 1'b1), '0));
      // ignored after the sequence ended
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_START, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'hFF, 1,
                              mk_rsp(8'h00, ST_FAULT, 1'b1), '0));
      // ignored while faulted
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h01, 1,
                              mk_rsp(8'hFF, ST_FINAL, 1'b1), '0));
      plan.push_back(cfg_row(32'hFFFF_FFFF));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h00, -1, '0, '0));
      // self loop on node 0, root branch 510 back to the root
      plan.push_back(item_row(ACT_LOAD, 8'd0, 16'h0000, 16'd256, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_LOAD, ROOT_NODE, 16'd256, 16'd510, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'hAA, -1, '0, '0));
      plan.push_back(item_row(ACT_LOAD, ROOT_NODE, 16'd511, 16'h0080, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h02, 1,
                              mk_rsp(8'h00, ST_FAULT, 1'b1), '0));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'h01, 2,
                              mk_rsp(8'h80, ST_BYTE, 1'b0), mk_rsp(8'h00, ST_FAULT, 1'b1)));
      plan.push_back(cfg_row(32'h0000_0000));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'hFF, -1, '0, '0));
      // upper write bits fall outside the register
      plan.push_back(cfg_row(32'hFF00_0003));
      plan.push_back(item_row(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, '0, '0));
      plan.push_back(item_row(ACT_DECODE, 8'h00, 16'h0000, 16'h0000, 8'hFF, -1, '0, '0));

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CFG) write_length(plan[r].cfg);
         else send_item(plan[r].it, plan[r].n_typed, plan[r].t0, plan[r].t1);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: len_val = 32'd1;
            1: len_val = DATA_BITS'($urandom_range(2, 6));
            2: len_val = 32'h00FF_FFFF;
            3: len_val = 32'd0;
            4: len_val = $urandom;
            5: len_val = DATA_BITS'($urandom_range(1, 12));
            default: len_val = DATA_BITS'($urandom_range(2, 20));
         endcase
         write_length(len_val);
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         it = random_item();
         it.act = ACT_START;
         send_item(it, -1, '0, '0);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            it = random_item();
            send_item(it, -1, '0, '0);
            if (it.act != ACT_NONE) phase_items++;
         end
      end

      push <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d length settings, %0d nodes loaded",
               items_sent, results_seen, cfg_writes, live_list.size());
      $display("%0d sequence ends and %0d bad pointers seen, %0d mismatches",
               final_seen, fault_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
